// ===== design/kphc_pkg.sv =====
// shared types and constants of the key press / hold classifier
// no dependencies; used by the top level and its checker
package kphc_pkg;

    // request, key code, timer and configuration port widths
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned CODE_W   = 7;
    localparam int unsigned TIMER_W  = 8;
    localparam int unsigned FRAC_W   = 4;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    // action codes of an input request
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK      = 2'd0,
        ACT_SAMPLE    = 2'd1,
        ACT_CLEAR     = 2'd2,
        ACT_WAIT_REL  = 2'd3
    } t_action;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_CLICK_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_MEMORY_TIME = 1'd1;

    // reset values of the configuration registers
    localparam logic [CODE_W-1:0]  FAST_CLICK_LIMIT_RST = 7'd3;
    localparam logic [TIMER_W-1:0] CODE_MEMORY_TIME_RST = 8'd10;

    // time base and code constants
    localparam logic [FRAC_W-1:0]  TENTH_LAST = 4'd9;
    localparam logic [TIMER_W-1:0] TIMER_MAX  = 8'd255;
    localparam logic [CODE_W-1:0]  HOLD_CAP   = 7'd99;
    localparam logic [CODE_W-1:0]  FAST_CODE  = 7'd100;
    localparam logic [CODE_W-1:0]  IDLE_CODE  = 7'd0;

endpackage

// ===== design/key_press_hold_classifier_unit.sv =====
// Key press / hold classifier: input register, one pass of logic, result register.
// A sample request's key code passes from the input register to the result register.
// Throughput: one request per cycle; only a sample waits, and only while the result
// register is full and stalled. Ticks, clears and waits give no result.
// Synchronous active-low reset: idle mode, cleared state, config registers 3 and 10.
// depends on kphc_pkg
module key_press_hold_classifier_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [kphc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kphc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // request channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [kphc_pkg::ACTION_W-1:0]        i_action,
    input  logic                                 i_key_level,
    // result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [kphc_pkg::CODE_W-1:0]          o_key_code
);
    import kphc_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_HELD     = 2'd1,
        MODE_MEMORY   = 2'd2,
        MODE_WAIT_LOW = 2'd3
    } t_mode;

    // configuration registers
    logic [CODE_W-1:0]  r_fast_click_limit;
    logic [TIMER_W-1:0] r_code_memory_time;

    // input register
    logic               r_in_valid;
    t_action            r_action;
    logic               r_key;

    // classifier state
    t_mode              r_mode,        n_mode;
    logic               r_last_level,  n_last_level;
    logic [CODE_W-1:0]  r_held_code,   n_held_code;
    logic [FRAC_W-1:0]  r_tick_frac,   n_tick_frac;
    logic [TIMER_W-1:0] r_hold_tenths, n_hold_tenths;

    // result register
    logic               r_out_valid;
    logic [CODE_W-1:0]  r_out_code,    n_out_code;

    logic               out_free;
    logic               is_sample;
    logic               advance;
    logic               in_accept;
    logic [CODE_W-1:0]  hold_code;
    logic [CODE_W-1:0]  hold_code_m1;
    logic [FRAC_W-1:0]  frac_inc;

    // handshake control
    assign out_free  = !r_out_valid || !i_stall;
    assign is_sample = (r_action == ACT_SAMPLE);
    assign advance   = r_in_valid && (!is_sample || out_free);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    // hold time plus one, capped
    assign hold_code    = (r_hold_tenths >= TIMER_W'(HOLD_CAP - 7'd1)) ? HOLD_CAP
                        : r_hold_tenths[CODE_W-1:0] + 7'd1;
    assign hold_code_m1 = hold_code - 7'd1;
    assign frac_inc     = r_tick_frac + 4'd1;

    // next state of the classifier for the request in the input register
    always_comb begin
        n_mode        = r_mode;
        n_last_level  = r_last_level;
        n_held_code   = r_held_code;
        n_tick_frac   = r_tick_frac;
        n_hold_tenths = r_hold_tenths;
        n_out_code    = IDLE_CODE;
        case (r_action)
            ACT_TICK: begin
                n_tick_frac = frac_inc;
                if (frac_inc > TENTH_LAST) begin
                    n_tick_frac = '0;
                    if (r_hold_tenths < TIMER_MAX) begin
                        n_hold_tenths = r_hold_tenths + 8'd1;
                    end
                end
            end
            ACT_SAMPLE: begin
                case (r_mode)
                    MODE_IDLE: begin
                        n_last_level = r_key;
                        if (!r_last_level && r_key) begin
                            n_tick_frac   = '0;
                            n_hold_tenths = '0;
                            n_mode        = MODE_HELD;
                        end
                    end
                    MODE_HELD: begin
                        n_held_code = hold_code;
                        n_out_code  = hold_code;
                        if (r_last_level && !r_key) begin
                            n_last_level  = 1'b0;
                            n_tick_frac   = '0;
                            n_hold_tenths = '0;
                            n_mode        = MODE_MEMORY;
                            if (hold_code_m1 < r_fast_click_limit) begin
                                n_held_code = FAST_CODE;
                                n_out_code  = FAST_CODE;
                            end
                        end
                    end
                    MODE_MEMORY: begin
                        if ((r_hold_tenths > 8'd1 && !r_last_level && r_key) ||
                            r_hold_tenths >= r_code_memory_time) begin
                            n_mode = MODE_IDLE;
                        end else begin
                            n_out_code = r_held_code;
                        end
                    end
                    default: begin
                        if (!r_key) begin
                            n_last_level = 1'b0;
                            n_mode       = MODE_IDLE;
                        end
                    end
                endcase
            end
            ACT_CLEAR: begin
                n_last_level = 1'b0;
                n_mode       = MODE_IDLE;
                n_held_code  = IDLE_CODE;
            end
            default: begin
                n_mode      = MODE_WAIT_LOW;
                n_held_code = IDLE_CODE;
            end
        endcase
    end

    // configuration, state, input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_click_limit <= FAST_CLICK_LIMIT_RST;
            r_code_memory_time <= CODE_MEMORY_TIME_RST;
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_mode             <= MODE_IDLE;
            r_last_level       <= 1'b0;
            r_held_code        <= IDLE_CODE;
            r_tick_frac        <= '0;
            r_hold_tenths      <= '0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FAST_CLICK_LIMIT: r_fast_click_limit <= i_cfg_data[CODE_W-1:0];
                    CFG_CODE_MEMORY_TIME: r_code_memory_time <= i_cfg_data;
                    default: ;
                endcase
            end
            // input register
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            // state update
            if (advance) begin
                r_mode        <= n_mode;
                r_last_level  <= n_last_level;
                r_held_code   <= n_held_code;
                r_tick_frac   <= n_tick_frac;
                r_hold_tenths <= n_hold_tenths;
            end
            // result register
            if (advance && is_sample) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= t_action'(i_action);
            r_key    <= i_key_level;
        end
        if (advance && is_sample) begin
            r_out_code <= n_out_code;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_key_code = r_out_code;

endmodule

// ===== design/kphc_checker.sv =====
// port-level checker of the key press / hold classifier, bound to the top level
// depends on kphc_pkg and key_press_hold_classifier_unit
module kphc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [kphc_pkg::CODE_W-1:0] o_key_code
);
    import kphc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_key_code))
        else $error("stalled result changed");

    // codes stay in range
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_key_code <= FAST_CODE)
        else $error("key code out of range");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // requests are held back only by a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("request stalled without output back-pressure");

endmodule

bind key_press_hold_classifier_unit kphc_checker u_kphc_checker (.*);

// ===== bench/tb.sv =====
// self-checking bench for key_press_hold_classifier_unit: a scoreboard class tracks
// the classifier state and the key codes due; plain tasks drive requests and config
// depends on kphc_pkg and the design top level
module tb;
    import kphc_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 2_000_000;
    localparam int unsigned PHASE_REQUESTS = 100;
    localparam int unsigned DRAIN_EXTRA    = 6;
    localparam int unsigned REPORT_MAX     = 10;

    // classifier modes as tracked by the scoreboard
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_HELD     = 2'd1,
        MODE_MEMORY   = 2'd2,
        MODE_WAIT_LOW = 2'd3
    } t_mode;

    // tracks the classifier state and the key codes still to arrive
    class key_code_board;
        logic [CODE_W-1:0]  fast_limit;
        logic [TIMER_W-1:0] memory_time;
        t_mode              mode;
        logic               last_level;
        logic [CODE_W-1:0]  held_code;
        logic [FRAC_W-1:0]  tick_frac;
        logic [TIMER_W-1:0] hold_tenths;
        logic [CODE_W-1:0]  codes_due[$];
        int unsigned        mismatches;

        function new();
            fast_limit  = FAST_CLICK_LIMIT_RST;
            memory_time = CODE_MEMORY_TIME_RST;
            mode        = MODE_IDLE;
            last_level  = 1'b0;
            held_code   = IDLE_CODE;
            tick_frac   = '0;
            hold_tenths = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FAST_CLICK_LIMIT)
                fast_limit = data[CODE_W-1:0];
            else
                memory_time = data[TIMER_W-1:0];
        endfunction

        // key code of one sample, with the mode machine step
        function logic [CODE_W-1:0] sample_code(logic key);
            logic [TIMER_W:0] code;
            case (mode)
                MODE_IDLE: begin
                    if (!last_level && key) begin
                        last_level  = 1'b1;
                        tick_frac   = '0;
                        hold_tenths = '0;
                        mode        = MODE_HELD;
                    end else begin
                        last_level = key;
                    end
                    return IDLE_CODE;
                end
                MODE_HELD: begin
                    code = {1'b0, hold_tenths} + 9'd1;
                    if (code > HOLD_CAP)
                        code = {2'b00, HOLD_CAP};
                    held_code = code[CODE_W-1:0];
                    // release: short holds turn into a fast click
                    if (last_level && !key) begin
                        last_level = 1'b0;
                        if (code - 1 < fast_limit)
                            held_code = FAST_CODE;
                        tick_frac   = '0;
                        hold_tenths = '0;
                        mode        = MODE_MEMORY;
                    end
                    return held_code;
                end
                MODE_MEMORY: begin
                    if ((hold_tenths > 1 && !last_level && key) ||
                        hold_tenths >= memory_time) begin
                        mode = MODE_IDLE;
                        return IDLE_CODE;
                    end
                    return held_code;
                end
                default: begin
                    if (!key) begin
                        last_level = 1'b0;
                        mode       = MODE_IDLE;
                    end
                    return IDLE_CODE;
                end
            endcase
        endfunction

        // one accepted request
        function void note_request(t_action act, logic key);
            case (act)
                ACT_TICK: begin
                    tick_frac = tick_frac + 1'b1;
                    if (tick_frac > TENTH_LAST) begin
                        tick_frac = '0;
                        if (hold_tenths < TIMER_MAX)
                            hold_tenths = hold_tenths + 1'b1;
                    end
                end
                ACT_SAMPLE: codes_due.push_back(sample_code(key));
                ACT_CLEAR: begin
                    last_level = 1'b0;
                    mode       = MODE_IDLE;
                    held_code  = IDLE_CODE;
                end
                default: begin
                    mode      = MODE_WAIT_LOW;
                    held_code = IDLE_CODE;
                end
            endcase
        endfunction

        // one accepted result against the oldest code due
        function void check_code(logic [CODE_W-1:0] got);
            logic [CODE_W-1:0] want;
            if (codes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected key code %0d", got);
                return;
            end
            want = codes_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("key code mismatch: expected %0d, actual %0d", want, got);
            end
        endfunction

        function int unsigned outstanding();
            return codes_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [ACTION_W-1:0]   i_action;
    logic                  i_key_level;
    logic                  o_valid;
    logic                  i_stall;
    logic [CODE_W-1:0]     o_key_code;

    key_code_board board = new();

    int unsigned cycles;
    int unsigned phase_count;
    bit          counting;
    bit          steady;
    int unsigned stall_left;
    logic        stall_value;
    int unsigned stall_pick;

    key_press_hold_classifier_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_key_level (i_key_level),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_key_code  (o_key_code)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: check accepted codes, stall in bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_code(o_key_code);
        if (stall_left == 0) begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 45) begin
                stall_value = 1'b0;
                stall_left  = $urandom_range(1, 40);
            end else if (stall_pick < 90) begin
                stall_value = 1'b1;
                stall_left  = $urandom_range(1, 3);
            end else if (stall_pick < 97) begin
                stall_value = 1'b1;
                stall_left  = $urandom_range(5, 15);
            end else begin
                stall_value = 1'b1;
                stall_left  = $urandom_range(30, 80);
            end
        end
        stall_left = stall_left - 1;
        i_stall <= stall_value;
    end

    // idle cycles between requests: mostly none, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // ticks between samples: short runs, some crossing several tenths
    function automatic int unsigned pick_ticks();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 3);
        if (r < 85)
            return $urandom_range(5, 15);
        return $urandom_range(20, 40);
    endfunction

    // one request, held until accepted
    task automatic send_request(input t_action act, input logic key);
        int unsigned gap;
        i_valid     <= 1'b1;
        i_action    <= act;
        i_key_level <= key;
        do @(posedge i_clk); while (o_stall);
        board.note_request(act, key);
        if (counting)
            phase_count++;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_request(ACT_TICK, 1'($urandom_range(0, 1)));
    endtask

    // stop requests until every code has arrived and the block has settled
    task automatic drain_codes();
        i_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_EXTRA) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(idx, data);
    endtask

    // press, hold with samples, release, then samples in the memory window
    task automatic press_episode(input bit long_run);
        int unsigned steps;
        repeat ($urandom_range(0, 2)) send_request(ACT_SAMPLE, 1'b0);
        send_request(ACT_SAMPLE, 1'b1);
        steps = long_run ? 10 : $urandom_range(0, 4);
        repeat (steps) begin
            send_ticks(long_run ? $urandom_range(260, 400) : pick_ticks());
            // broken sequence now and then
            if ($urandom_range(0, 19) == 0)
                send_request($urandom_range(0, 1) ? ACT_CLEAR : ACT_WAIT_REL,
                             1'($urandom_range(0, 1)));
            send_request(ACT_SAMPLE, 1'b1);
        end
        send_request(ACT_SAMPLE, 1'b0);
        steps = long_run ? 10 : $urandom_range(0, 4);
        repeat (steps) begin
            send_ticks(long_run ? $urandom_range(260, 400) : pick_ticks());
            send_request(ACT_SAMPLE, long_run ? 1'b0 : 1'($urandom_range(0, 3) == 0));
        end
    endtask

    task automatic noise_episode();
        repeat ($urandom_range(1, 8))
            send_request(t_action'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int unsigned phase;
        cycles      = 0;
        stall_left  = 0;
        stall_value = 1'b0;
        steady      = 1'b0;
        counting    = 1'b0;
        phase_count = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_FAST_CLICK_LIMIT;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_action    <= ACT_TICK;
        i_key_level <= 1'b0;
        i_stall     <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle, press, hold, fast click, press inside the memory window
        send_request(ACT_SAMPLE, 1'b0);
        send_request(ACT_SAMPLE, 1'b1);
        send_request(ACT_SAMPLE, 1'b1);
        send_request(ACT_SAMPLE, 1'b0);
        send_request(ACT_SAMPLE, 1'b1);
        // clear, then forced wait for release
        send_request(ACT_CLEAR, 1'b1);
        send_request(ACT_SAMPLE, 1'b0);
        send_request(ACT_SAMPLE, 1'b1);
        send_request(ACT_WAIT_REL, 1'b0);
        send_request(ACT_SAMPLE, 1'b1);
        send_request(ACT_SAMPLE, 1'b0);
        send_request(ACT_TICK, 1'b0);
        send_request(ACT_TICK, 1'b1);
        send_request(ACT_SAMPLE, 1'b1);
        send_request(ACT_SAMPLE, 1'b0);

        // fast click limit above the cap, zero memory time
        drain_codes();
        write_reg(CFG_FAST_CLICK_LIMIT, 8'hFF);
        write_reg(CFG_CODE_MEMORY_TIME, 8'h00);
        send_request(ACT_SAMPLE, 1'b1);
        send_request(ACT_SAMPLE, 1'b1);
        send_request(ACT_SAMPLE, 1'b0);
        send_request(ACT_SAMPLE, 1'b0);
        send_request(ACT_SAMPLE, 1'b0);

        // random phases, one setting each
        for (phase = 0; phase < 6; phase++) begin
            drain_codes();
            case (phase)
                0: begin
                    write_reg(CFG_FAST_CLICK_LIMIT, 8'h00);
                    write_reg(CFG_CODE_MEMORY_TIME, 8'h00);
                end
                1: begin
                    write_reg(CFG_FAST_CLICK_LIMIT, 8'd99);
                    write_reg(CFG_CODE_MEMORY_TIME, 8'hFF);
                end
                2: begin
                    write_reg(CFG_FAST_CLICK_LIMIT, 8'hFF);
                    write_reg(CFG_CODE_MEMORY_TIME, 8'd1);
                end
                3: begin
                    write_reg(CFG_FAST_CLICK_LIMIT, 8'($urandom_range(0, 255)));
                    write_reg(CFG_CODE_MEMORY_TIME, 8'($urandom_range(0, 255)));
                end
                4: begin
                    write_reg(CFG_FAST_CLICK_LIMIT, 8'h83);
                    write_reg(CFG_CODE_MEMORY_TIME, 8'd10);
                end
                default: begin
                    write_reg(CFG_FAST_CLICK_LIMIT, 8'($urandom_range(1, 10)));
                    write_reg(CFG_CODE_MEMORY_TIME, 8'($urandom_range(20, 60)));
                end
            endcase
            counting    = 1'b1;
            phase_count = 0;
            while (phase_count < PHASE_REQUESTS) begin
                steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 75)
                    press_episode(1'b0);
                else
                    noise_episode();
                if ($urandom_range(0, 14) == 0)
                    drain_codes();
            end
            counting = 1'b0;
        end

        drain_codes();
        if (board.outstanding() != 0)
            board.mismatches++;
        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/kphc_pkg.sv
design/key_press_hold_classifier_unit.sv
design/kphc_checker.sv
bench/tb.sv
